### rtl/pltc_pkg.sv
// ----------------------------------------------------------------------------
// pltc_pkg
// Shared types and constants of the piecewise-linear table converter.
// ----------------------------------------------------------------------------
package pltc_pkg;

    localparam int POINTS_DEFAULT = 33;

    localparam int ADC_W = 12;
    localparam int VAL_W = 16;
    localparam int IDX_W = 6;

    // Interpolation divide: |dy * (x - x1)| fits in 28 bits, |dx| in 12 bits.
    localparam int NUM_W = 28;
    localparam int DEN_W = 12;

    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    // One calibration point as kept in the table memory.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ADC_W-1:0] adc;
    } point_t;

endpackage

### rtl/pltc_div.sv
// ----------------------------------------------------------------------------
// pltc_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pltc_div
    import pltc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0] q_reg,     q_next;
    logic [DEN_W-1:0] rem_reg,   rem_next;
    logic [DEN_W-1:0] den_reg,   den_next;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;

    assign rem_shift = {rem_reg, q_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            q_next    = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            // The numerator shifts out at the top while quotient bits enter below.
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_diff[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            q_reg    <= q_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### rtl/piecewise_linear_table_convert.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_convert
// Converts a 12-bit ADC sample to an engineering value through a calibration
// table with linear interpolation between points.
// ----------------------------------------------------------------------------
// A request with opcode write stores one calibration point (ADC value and
// output value) at point_index and produces no result; an index at or above
// POINTS is ignored. A request with opcode convert produces exactly one
// result. The table sits in one synchronous memory with a single read port,
// so every table access is registered: a sample at or below the first point
// reads only that point, one at or above the last point also reads the last,
// and any other sample reads the segment found by the previous conversion,
// walks from there one segment at a time and, when interpolation is needed,
// divides with the 28-bit serial divider. The ADC values of the table must
// be strictly increasing and every point must be written before the first
// conversion; the table has no reset. The result sits in an output register,
// so a new request is taken while a result waits.
// ----------------------------------------------------------------------------
module piecewise_linear_table_convert
    import pltc_pkg::*;
#(
    parameter int POINTS = POINTS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             opcode,
    input  logic [IDX_W-1:0] point_index,
    input  logic [ADC_W-1:0] point_adc,
    input  logic [VAL_W-1:0] point_value,
    input  logic [ADC_W-1:0] sample,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [VAL_W-1:0] value,
    output logic             below_range,
    output logic             above_range
);

    localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int NW = $clog2(POINTS + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(POINTS - 1);
    localparam logic [AW-1:0] SEG_MAX  = AW'(POINTS - 2);
    localparam int PROD_W = 30;
    localparam int SUM_W  = 30;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_LO,
        S_HI,
        S_SEARCH,
        S_FETCH,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_PUSH
    } state_t;

    // Table memory and its registered read port.
    point_t mem [POINTS];
    point_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    state_t           state_reg,     state_next;
    logic [ADC_W-1:0] x_reg,         x_next;
    logic [AW-1:0]    seg_reg,       seg_next;
    logic [AW-1:0]    s_reg,         s_next;
    logic [NW-1:0]    n_reg,         n_next;
    logic             up_reg,        up_next;
    point_t           lo_reg,        lo_next;
    point_t           hi_reg,        hi_next;
    logic [NUM_W-1:0] num_reg,       num_next;
    logic [DEN_W-1:0] den_reg,       den_next;
    logic             neg_reg,       neg_next;
    logic [VAL_W-1:0] res_value_reg, res_value_next;
    logic             res_below_reg, res_below_next;
    logic             res_above_reg, res_above_next;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] value_reg,     value_next;
    logic             below_reg,     below_next;
    logic             above_reg,     above_next;

    logic [AW-1:0]        seg_clamped;
    logic [AW-1:0]        s_up;
    logic                 in_seg;
    logic signed [16:0]   dy;
    logic signed [12:0]   xd;
    logic signed [12:0]   dx;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]    prod_mag;
    logic [12:0]          dx_mag;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quot;
    logic signed [SUM_W-1:0] q_signed;
    logic signed [SUM_W-1:0] sum;
    logic                 out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign wr_en = in_valid && in_ready && (opcode == OP_WRITE)
                   && ({1'b0, point_index} < (IDX_W + 1)'(POINTS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[point_index[AW-1:0]] <= '{value: point_value, adc: point_adc};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // The remembered segment is kept in range before the search starts.
    assign seg_clamped = (seg_reg > SEG_MAX) ? SEG_MAX : seg_reg;
    assign s_up        = (s_reg >= SEG_MAX) ? SEG_MAX : s_reg + AW'(1);
    assign in_seg      = (x_reg >= lo_reg.adc) && (x_reg <= hi_reg.adc);

    // Interpolation terms: dy * (x - x1) / dx, all signed so that a malformed
    // table still truncates toward zero.
    assign dy   = $signed({1'b0, hi_reg.value}) - $signed({1'b0, lo_reg.value});
    assign xd   = $signed({1'b0, x_reg}) - $signed({1'b0, lo_reg.adc});
    assign dx   = $signed({1'b0, hi_reg.adc}) - $signed({1'b0, lo_reg.adc});
    assign prod = PROD_W'(dy) * PROD_W'(xd);
    assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    assign dx_mag   = dx[12] ? 13'(-dx) : 13'(dx);

    assign div_start = (state_reg == S_DSTART);

    pltc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (num_reg),
        .denom (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign q_signed = neg_reg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
    assign sum      = $signed({{(SUM_W - VAL_W){1'b0}}, lo_reg.value}) + q_signed;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        seg_next       = seg_reg;
        s_next         = s_reg;
        n_next         = n_reg;
        up_next        = up_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        res_value_next = res_value_reg;
        res_below_next = res_below_reg;
        res_above_next = res_above_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        below_next     = below_reg;
        above_next     = above_reg;
        rd_addr        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // Entry 0 is read every idle cycle so it is ready for a conversion.
                if (in_valid && (opcode == OP_CONVERT))
                begin
                    x_next     = sample;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (x_reg <= rd_data_reg.adc)
                begin
                    res_value_next = rd_data_reg.value;
                    res_below_next = 1'b1;
                    res_above_next = 1'b0;
                    state_next     = S_PUSH;
                end
                else
                begin
                    rd_addr    = LAST_IDX;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (x_reg >= rd_data_reg.adc)
                begin
                    res_value_next = rd_data_reg.value;
                    res_below_next = 1'b0;
                    res_above_next = 1'b1;
                    state_next     = S_PUSH;
                end
                else
                begin
                    rd_addr    = seg_clamped;
                    s_next     = seg_clamped;
                    state_next = S_LO;
                end
            end
            S_LO:
            begin
                rd_addr    = s_reg + AW'(1);
                lo_next    = rd_data_reg;
                state_next = S_HI;
            end
            S_HI:
            begin
                hi_next    = rd_data_reg;
                n_next     = '0;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (in_seg || (n_reg == NW'(POINTS)))
                begin
                    seg_next       = s_reg;
                    res_below_next = 1'b0;
                    res_above_next = 1'b0;
                    if ((x_reg == lo_reg.adc) || (hi_reg.adc == lo_reg.adc))
                    begin
                        res_value_next = lo_reg.value;
                        state_next     = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    n_next = n_reg + NW'(1);
                    if (x_reg > lo_reg.adc)
                    begin
                        // Walking up: the old upper point becomes the lower one.
                        if (s_up != s_reg)
                        begin
                            s_next     = s_up;
                            lo_next    = hi_reg;
                            up_next    = 1'b1;
                            rd_addr    = s_up + AW'(1);
                            state_next = S_FETCH;
                        end
                    end
                    else if (s_reg != '0)
                    begin
                        // Walking down: the old lower point becomes the upper one.
                        s_next     = s_reg - AW'(1);
                        hi_next    = lo_reg;
                        up_next    = 1'b0;
                        rd_addr    = s_reg - AW'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (up_reg)
                begin
                    hi_next = rd_data_reg;
                end
                else
                begin
                    lo_next = rd_data_reg;
                end
                state_next = S_SEARCH;
            end
            S_MUL:
            begin
                num_next   = prod_mag[NUM_W-1:0];
                den_next   = dx_mag[DEN_W-1:0];
                neg_next   = prod[PROD_W-1] ^ dx[12];
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    // Saturate the interpolated value to the output range.
                    if (sum < 0)
                    begin
                        res_value_next = '0;
                    end
                    else if (sum > $signed(SUM_W'(65535)))
                    begin
                        res_value_next = '1;
                    end
                    else
                    begin
                        res_value_next = sum[VAL_W-1:0];
                    end
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_value_reg;
                    below_next     = res_below_reg;
                    above_next     = res_above_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_reg         <= '0;
            seg_reg       <= '0;
            s_reg         <= '0;
            n_reg         <= '0;
            up_reg        <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            neg_reg       <= 1'b0;
            res_value_reg <= '0;
            res_below_reg <= 1'b0;
            res_above_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            below_reg     <= 1'b0;
            above_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            seg_reg       <= seg_next;
            s_reg         <= s_next;
            n_reg         <= n_next;
            up_reg        <= up_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            neg_reg       <= neg_next;
            res_value_reg <= res_value_next;
            res_below_reg <= res_below_next;
            res_above_reg <= res_above_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
            below_reg     <= below_next;
            above_reg     <= above_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign below_range = below_reg;
    assign above_range = above_reg;

endmodule
